@@ hw/rtl/lisk_pkg.sv @@
`default_nettype none
package lisk_pkg;

   localparam int MAX_HALF  = 15;
   localparam int MAX_LEN   = 4096;
   localparam int FRAC_BITS = 16;

   localparam int CHAR_W    = 8;
   localparam int HALF_W    = 4;
   localparam int INNER_W   = 4;
   localparam int OUTER_W   = 2;
   localparam int VALUE_W   = 48;

   localparam int WIN_W     = 2 * MAX_HALF + 1;
   localparam int BIT_IDX_W = $clog2(WIN_W + 1);
   localparam int LEN_W     = BIT_IDX_W;
   localparam int COUNT_W   = $clog2(MAX_LEN + 1);
   localparam int SUM_W     = $clog2((MAX_HALF + 1) * (MAX_HALF + 1) + 1);
   localparam int DIV_W     = $clog2(WIN_W * (MAX_HALF + 1) + 1);
   localparam int FRAC_W    = FRAC_BITS + 1;
   localparam int LANES     = 4;
   localparam int LANE_W    = $clog2(LANES);
   localparam int GROUP_W   = BIT_IDX_W - LANE_W;
   localparam int CNT_W     = 5;
   localparam int CHUNK_W   = 16;
   localparam int CHUNKS    = VALUE_W / CHUNK_W;
   localparam int CHUNK_IDX_W = 2;
   localparam int PART_W    = VALUE_W + CHUNK_W;
   localparam int PROD_W    = 2 * VALUE_W;
   localparam int KEEP_W    = VALUE_W + FRAC_BITS;
   localparam int MCNT_W    = 2;

   localparam logic [VALUE_W-1:0] VALUE_MAX = {VALUE_W{1'b1}};
   localparam logic [FRAC_W-1:0]  FRAC_ONE  = FRAC_W'(1) << FRAC_BITS;

   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;
   localparam int REG_IDX_W  = 2;

   localparam logic [REG_IDX_W-1:0] REG_HALF_WINDOW = 2'd0;
   localparam logic [REG_IDX_W-1:0] REG_INNER_POWER = 2'd1;
   localparam logic [REG_IDX_W-1:0] REG_OUTER_POWER = 2'd2;

   localparam logic [HALF_W-1:0]  HALF_RESET  = 4'd3;
   localparam logic [INNER_W-1:0] INNER_RESET = 4'd2;
   localparam logic [OUTER_W-1:0] OUTER_RESET = 2'd1;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_START,
      ST_SUM,
      ST_DIV,
      ST_POW,
      ST_ACC,
      ST_OLOAD,
      ST_OMUL,
      ST_OFIN,
      ST_EMIT
   } lisk_state_type;

   typedef struct packed {
      logic load;
      logic sum_clr;
      logic sum_step;
      logic cnt_clr;
      logic cnt_inc;
      logic div_step;
      logic pow_step;
      logic acc_add;
      logic out_load;
      logic omul_step;
      logic ofin;
      logic emit;
   } lisk_cmd_type;

   typedef struct packed {
      logic full;
      logic last;
      logic sum_done;
      logic div_done;
      logic inner_more;
      logic pow_last;
      logic outer_more;
      logic omul_done;
      logic ofin_more;
   } lisk_status_type;

endpackage
`default_nettype wire

@@ hw/rtl/locality_improved_string_kernel.sv @@
`default_nettype none
// Locality-improved string kernel over two equal-length byte strings.
// Input channel (req_): one position per transaction, a_char and b_char,
// with last on the final position. Result channel (rsp_): one transaction
// per string, kernel_value in unsigned Q32.16 and saturated.
// Configuration through the APB port (csr_): half_window at 0x0,
// inner power at 0x4, outer power at 0x8; write only while idle.
// Per position the match bit shifts into the window; once 2L+1 positions
// have been seen, the window sum (4 lanes of the window sum per cycle),
// a radix-2 divider and one 17x17 multiply per degree step for the inner
// power (0 counts as 1) give a fraction that is added to the accumulator.
// A last position raises the accumulator to the outer power P
// (48x16 partial products, three per multiply) before the result register
// and rsp_valid are loaded.
// The result register frees the controller: a new string may start while
// a result waits; a second result waits for rsp_ready before req_ready
// rises again. Reset clears the string state and loads default registers.
module locality_improved_string_kernel
   import lisk_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire logic [CHAR_W-1:0]     req_a_char,
   input  wire logic [CHAR_W-1:0]     req_b_char,
   input  wire logic                  req_last,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output logic [VALUE_W-1:0]         rsp_kernel_value,
   output logic                       rsp_saturated,
   input  wire logic                  csr_psel,
   input  wire logic                  csr_penable,
   input  wire logic                  csr_pwrite,
   input  wire logic [CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0]      csr_prdata,
   output logic                       csr_pready
);

   logic [HALF_W-1:0]  half_ff, half_in;
   logic [INNER_W-1:0] inner_ff, inner_in;
   logic [OUTER_W-1:0] outer_ff, outer_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [VALUE_W-1:0] rsp_value_ff, rsp_value_in;
   logic               rsp_sat_ff, rsp_sat_in;

   logic [REG_IDX_W-1:0] reg_idx;
   logic                 csr_write;
   logic                 out_free;
   lisk_cmd_type         cmd;
   lisk_status_type      status;
   logic [VALUE_W-1:0]   result_value;
   logic                 result_clip;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign reg_idx    = csr_paddr[CSR_ADDR_W-1:2];

   always_comb begin
      half_in  = half_ff;
      inner_in = inner_ff;
      outer_in = outer_ff;
      if (csr_write) begin
         unique case (reg_idx)
            REG_HALF_WINDOW: half_in  = csr_pwdata[HALF_W-1:0];
            REG_INNER_POWER: inner_in = csr_pwdata[INNER_W-1:0];
            REG_OUTER_POWER: outer_in = csr_pwdata[OUTER_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (reg_idx)
         REG_HALF_WINDOW: csr_prdata = CSR_DATA_W'(half_ff);
         REG_INNER_POWER: csr_prdata = CSR_DATA_W'(inner_ff);
         REG_OUTER_POWER: csr_prdata = CSR_DATA_W'(outer_ff);
         default:         csr_prdata = '0;
      endcase
   end

   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_value_in = rsp_value_ff;
      rsp_sat_in   = rsp_sat_ff;
      if (rsp_ready) rsp_valid_in = 1'b0;
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
         rsp_value_in = result_value;
         rsp_sat_in   = result_clip;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         half_ff      <= HALF_RESET;
         inner_ff     <= INNER_RESET;
         outer_ff     <= OUTER_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         half_ff      <= half_in;
         inner_ff     <= inner_in;
         outer_ff     <= outer_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_value_ff <= rsp_value_in;
      rsp_sat_ff   <= rsp_sat_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_kernel_value = rsp_value_ff;
   assign rsp_saturated    = rsp_sat_ff;

   lisk_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .out_free  (out_free),
      .cmd       (cmd)
   );

   lisk_dp u_dp (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .a_char       (req_a_char),
      .b_char       (req_b_char),
      .last         (req_last),
      .half_window  (half_ff),
      .inner_exp    (inner_ff),
      .outer_exp    (outer_ff),
      .status       (status),
      .result_value (result_value),
      .result_clip  (result_clip)
   );

endmodule
`default_nettype wire

@@ hw/rtl/lisk_ctrl.sv @@
`default_nettype none
module lisk_ctrl
   import lisk_pkg::*;
(
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_valid,
   output logic                 req_ready,
   input  wire lisk_status_type status,
   input  wire logic            out_free,
   output lisk_cmd_type         cmd
);

   lisk_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_START;
         end
         ST_START: begin
            if (status.full) state_in = ST_SUM;
            else if (status.last) state_in = ST_OLOAD;
            else state_in = ST_IDLE;
         end
         ST_SUM: begin
            if (status.sum_done) state_in = ST_DIV;
         end
         ST_DIV: begin
            if (status.div_done) state_in = status.inner_more ? ST_POW : ST_ACC;
         end
         ST_POW: begin
            if (status.pow_last) state_in = ST_ACC;
         end
         ST_ACC: begin
            state_in = status.last ? ST_OLOAD : ST_IDLE;
         end
         ST_OLOAD: begin
            state_in = status.outer_more ? ST_OMUL : ST_EMIT;
         end
         ST_OMUL: begin
            if (status.omul_done) state_in = ST_OFIN;
         end
         ST_OFIN: begin
            state_in = status.ofin_more ? ST_OMUL : ST_EMIT;
         end
         ST_EMIT: begin
            if (out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            cmd.load = req_valid;
         end
         ST_START: begin
            cmd.sum_clr = status.full;
            cmd.cnt_clr = 1'b1;
         end
         ST_SUM: begin
            cmd.sum_step = 1'b1;
            cmd.cnt_inc = 1'b1;
            cmd.cnt_clr = status.sum_done;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            cmd.cnt_inc = 1'b1;
            cmd.cnt_clr = status.div_done;
         end
         ST_POW: begin
            cmd.pow_step = 1'b1;
            cmd.cnt_inc = 1'b1;
         end
         ST_ACC: begin
            cmd.acc_add = 1'b1;
         end
         ST_OLOAD: begin
            cmd.out_load = 1'b1;
            cmd.cnt_clr = 1'b1;
         end
         ST_OMUL: begin
            cmd.omul_step = 1'b1;
            cmd.cnt_inc = 1'b1;
         end
         ST_OFIN: begin
            cmd.ofin = 1'b1;
            cmd.cnt_clr = 1'b1;
         end
         ST_EMIT: begin
            cmd.emit = out_free;
         end
         default: cmd = '0;
      endcase
   end

endmodule
`default_nettype wire

@@ hw/rtl/lisk_dp.sv @@
`default_nettype none
module lisk_dp
   import lisk_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire lisk_cmd_type       cmd,
   input  wire logic [CHAR_W-1:0]  a_char,
   input  wire logic [CHAR_W-1:0]  b_char,
   input  wire logic               last,
   input  wire logic [HALF_W-1:0]  half_window,
   input  wire logic [INNER_W-1:0] inner_exp,
   input  wire logic [OUTER_W-1:0] outer_exp,
   output lisk_status_type         status,
   output logic [VALUE_W-1:0]      result_value,
   output logic                    result_clip
);

   logic [WIN_W-1:0]   window_ff, window_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic               last_ff, last_in;
   logic [SUM_W-1:0]   sum_ff, sum_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic [DIV_W-1:0]   rem_ff, rem_in;
   logic [FRAC_W-1:0]  q_ff, q_in;
   logic [FRAC_W-1:0]  p_ff, p_in;
   logic [VALUE_W-1:0] acc_ff, acc_in;
   logic [VALUE_W-1:0] r_ff, r_in;
   logic               clip_ff, clip_in;
   logic [PROD_W-1:0]  prod_ff, prod_in;
   logic [MCNT_W-1:0]  mcnt_ff, mcnt_in;

   logic [LEN_W-1:0]     wlen;
   logic [LEN_W-1:0]     half_p1;
   logic [2*LEN_W-1:0]   div_full;
   logic [DIV_W-1:0]     divisor;
   logic [INNER_W-1:0]   inner_eff;
   logic [OUTER_W-1:0]   outer_eff;
   logic [WIN_W:0]       win_ext;
   logic [SUM_W-1:0]     part;
   logic [DIV_W-1:0]     sum_ext;
   logic                 ge_int;
   logic [DIV_W:0]       rem_sh;
   logic                 ge_frac;
   logic                 q_bit;
   logic [2*FRAC_W-1:0]  pow_full;
   logic [VALUE_W:0]     acc_sum;
   logic [CHUNK_IDX_W-1:0] chunk_sel;
   logic [CHUNK_W-1:0]   chunk;
   logic [PART_W-1:0]    part_prod;
   logic                 over;

   assign wlen      = {half_window, 1'b1};
   assign half_p1   = LEN_W'(half_window) + LEN_W'(1);
   assign div_full  = wlen * half_p1;
   assign divisor   = div_full[DIV_W-1:0];
   assign inner_eff = (inner_exp == '0) ? INNER_W'(1) : inner_exp;
   assign outer_eff = (outer_exp == '0) ? OUTER_W'(1) : outer_exp;
   assign win_ext   = {1'b0, window_ff};

   always_comb begin
      logic [BIT_IDX_W-1:0] b;
      logic [BIT_IDX_W:0]   up;
      logic [BIT_IDX_W:0]   down;
      part = '0;
      for (int j = 0; j < LANES; j++) begin
         b = {cnt_ff[GROUP_W-1:0], LANE_W'(j)};
         up = {1'b0, b} + (BIT_IDX_W + 1)'(1);
         down = {1'b0, wlen} - {1'b0, b};
         if ((b < wlen) && win_ext[b]) begin
            part = part + SUM_W'((up < down) ? up : down);
         end
      end
   end

   assign sum_ext = DIV_W'(sum_ff);
   assign ge_int  = sum_ext >= divisor;
   assign rem_sh  = {rem_ff, 1'b0};
   assign ge_frac = rem_sh >= {1'b0, divisor};
   assign q_bit   = (cnt_ff == '0) ? ge_int : ge_frac;

   assign pow_full = p_ff * q_ff;
   assign acc_sum  = {1'b0, acc_ff} + (VALUE_W + 1)'(p_ff);

   assign chunk_sel = CHUNK_IDX_W'(CHUNKS - 1) - cnt_ff[CHUNK_IDX_W-1:0];
   assign chunk     = acc_ff[chunk_sel * CHUNK_W +: CHUNK_W];
   assign part_prod = r_ff * chunk;
   assign over      = |prod_ff[PROD_W-1:KEEP_W];

   always_comb begin
      window_in = window_ff;
      count_in  = count_ff;
      last_in   = last_ff;
      sum_in    = sum_ff;
      cnt_in    = cnt_ff;
      rem_in    = rem_ff;
      q_in      = q_ff;
      p_in      = p_ff;
      acc_in    = acc_ff;
      r_in      = r_ff;
      clip_in   = clip_ff;
      prod_in   = prod_ff;
      mcnt_in   = mcnt_ff;

      if (cmd.load) begin
         window_in = {window_ff[WIN_W-2:0], a_char == b_char};
         if (count_ff < COUNT_W'(MAX_LEN)) count_in = count_ff + COUNT_W'(1);
         last_in = last;
      end
      if (cmd.sum_clr) sum_in = '0;
      if (cmd.sum_step) sum_in = sum_ff + part;
      if (cmd.cnt_inc) cnt_in = cnt_ff + CNT_W'(1);
      if (cmd.cnt_clr) cnt_in = '0;
      if (cmd.div_step) begin
         if (cnt_ff == '0) begin
            rem_in = ge_int ? sum_ext - divisor : sum_ext;
         end else begin
            rem_in = DIV_W'(ge_frac ? rem_sh - {1'b0, divisor} : rem_sh);
         end
         q_in = {q_ff[FRAC_W-2:0], q_bit};
         p_in = {q_ff[FRAC_W-2:0], q_bit};
      end
      if (cmd.pow_step) p_in = pow_full[FRAC_BITS +: FRAC_W];
      if (cmd.acc_add) acc_in = acc_sum[VALUE_W] ? VALUE_MAX : acc_sum[VALUE_W-1:0];
      if (cmd.out_load) begin
         r_in    = acc_ff;
         clip_in = acc_ff == VALUE_MAX;
         mcnt_in = '0;
      end
      if (cmd.omul_step) begin
         prod_in = ((cnt_ff == '0) ? '0 : (prod_ff << CHUNK_W)) + PROD_W'(part_prod);
      end
      if (cmd.ofin) begin
         r_in    = over ? VALUE_MAX : prod_ff[FRAC_BITS +: VALUE_W];
         clip_in = clip_ff | over;
         mcnt_in = mcnt_ff + MCNT_W'(1);
      end
      if (cmd.emit) begin
         window_in = '0;
         count_in  = '0;
         acc_in    = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff <= '0;
         count_ff  <= '0;
         acc_ff    <= '0;
         last_ff   <= 1'b0;
         cnt_ff    <= '0;
         mcnt_ff   <= '0;
      end else begin
         window_ff <= window_in;
         count_ff  <= count_in;
         acc_ff    <= acc_in;
         last_ff   <= last_in;
         cnt_ff    <= cnt_in;
         mcnt_ff   <= mcnt_in;
      end
   end

   always_ff @(posedge clock) begin
      sum_ff  <= sum_in;
      rem_ff  <= rem_in;
      q_ff    <= q_in;
      p_ff    <= p_in;
      r_ff    <= r_in;
      clip_ff <= clip_in;
      prod_ff <= prod_in;
   end

   always_comb begin
      status.full       = count_ff >= COUNT_W'(wlen);
      status.last       = last_ff;
      status.sum_done   = cnt_ff[GROUP_W-1:0] == half_window[HALF_W-1:1];
      status.div_done   = cnt_ff == CNT_W'(FRAC_BITS);
      status.inner_more = inner_eff > INNER_W'(1);
      status.pow_last   = (CNT_W'(cnt_ff) + CNT_W'(2)) >= CNT_W'(inner_eff);
      status.outer_more = outer_eff > OUTER_W'(1);
      status.omul_done  = cnt_ff[CHUNK_IDX_W-1:0] == CHUNK_IDX_W'(CHUNKS - 1);
      status.ofin_more  = (3'(mcnt_ff) + 3'd2) < 3'(outer_eff);
   end

   assign result_value = r_ff;
   assign result_clip  = clip_ff;

`ifndef ASSERT_OFF
   a_rem_below_divisor: assert property (@(posedge clock) disable iff (reset)
      cmd.div_step |=> rem_ff < divisor)
      else $error("remainder not below divisor after division step");

   a_frac_in_range: assert property (@(posedge clock) disable iff (reset)
      cmd.acc_add |-> p_ff <= FRAC_ONE)
      else $error("window fraction above one");

   a_clear_after_emit: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |=> (count_ff == '0) && (acc_ff == '0) && (window_ff == '0))
      else $error("string state not cleared after result");
`endif

endmodule
`default_nettype wire
